// ===== hdl/i2cmb_pkg.sv =====
// Shared types, constants and sequence tables of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cmb_pkg;

	// Queue between the front and the back part
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Field widths
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TDATA_W = 16;
	localparam int unsigned TUSER_W = 4;

	localparam logic [HOLD_W-1:0] STEP_RESET = 16'd10;

	// Bus commands
	typedef enum logic [2:0] {
		OP_START,
		OP_STOP,
		OP_WRITE,
		OP_READ,
		OP_SACK,
		OP_RACK
	} op_t;

	// Pin actions
	typedef enum logic [2:0] {
		ACT_SDA_LO,
		ACT_SDA_HI,
		ACT_SCL_LO,
		ACT_SCL_HI,
		ACT_SDA_DATA,
		ACT_SDA_ACK,
		ACT_RD_BIT,
		ACT_RD_ACK
	} act_t;

	// Classified input word as held in the queue
	typedef struct packed {
		logic              cmd_ok;
		op_t               op;
		logic [BYTE_W-1:0] tx_byte;
		logic              sda_in;
	} item_t;

	// Result word, scl in the lowest bit
	typedef struct packed {
		logic              rx_ack;
		logic [BYTE_W-1:0] rx_byte;
		logic              done;
		logic              busy;
		logic              sda;
		logic              scl;
	} result_t;

	// Queue status seen by the front part
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Number of pin actions in each command
	function automatic logic [IDX_W-1:0] seq_len(op_t op);
		logic [IDX_W-1:0] len;
		unique case (op)
			OP_START: len = 5'd4;
			OP_STOP:  len = 5'd3;
			OP_WRITE: len = 5'd24;
			OP_READ:  len = 5'd25;
			OP_SACK:  len = 5'd3;
			default:  len = 5'd4;
		endcase
		return len;
	endfunction

	// Pin action at a given place in a command; phase is the place within a bit slot
	function automatic act_t action_kind(op_t op, logic [IDX_W-1:0] idx, logic [1:0] phase);
		act_t act;
		unique case (op)
			OP_START: begin
				unique case (idx[1:0])
					2'd0:    act = ACT_SDA_HI;
					2'd1:    act = ACT_SCL_HI;
					2'd2:    act = ACT_SDA_LO;
					default: act = ACT_SCL_LO;
				endcase
			end
			OP_STOP: begin
				if (idx == '0)
					act = ACT_SDA_LO;
				else if (idx == 5'd1)
					act = ACT_SCL_HI;
				else
					act = ACT_SDA_HI;
			end
			OP_WRITE: begin
				if (phase == 2'd0)
					act = ACT_SDA_DATA;
				else if (phase == 2'd1)
					act = ACT_SCL_HI;
				else
					act = ACT_SCL_LO;
			end
			OP_READ: begin
				if (idx == '0)
					act = ACT_SDA_HI;
				else if (phase == 2'd0)
					act = ACT_SCL_HI;
				else if (phase == 2'd1)
					act = ACT_RD_BIT;
				else
					act = ACT_SCL_LO;
			end
			OP_SACK: begin
				if (idx == '0)
					act = ACT_SDA_ACK;
				else if (idx == 5'd1)
					act = ACT_SCL_HI;
				else
					act = ACT_SCL_LO;
			end
			default: begin
				unique case (idx[1:0])
					2'd0:    act = ACT_SDA_HI;
					2'd1:    act = ACT_SCL_HI;
					2'd2:    act = ACT_RD_ACK;
					default: act = ACT_SCL_LO;
				endcase
			end
		endcase
		return act;
	endfunction

endpackage

// ===== hdl/i2cmb_front.sv =====
// Input stage: takes stream words, classifies the command and feeds the queue.
`timescale 1ns / 1ps

module i2cmb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [i2cmb_pkg::TDATA_W-1:0]     s_tdata,  // tx_byte[7:0], sda_in[8], zero pad
	input  logic [i2cmb_pkg::TUSER_W-1:0]     s_tuser,  // cmd_valid[0], opcode[3:1]
	input  i2cmb_pkg::q_stat_t                q_stat,
	output logic                              push,
	output i2cmb_pkg::item_t                  push_item
);

	logic             valid_s1;
	i2cmb_pkg::item_t item_s1;
	i2cmb_pkg::item_t item_in;

	// Classify: only known opcodes with cmd_valid count as commands
	always_comb begin
		item_in.cmd_ok  = s_tuser[0] & (s_tuser[3:1] <= i2cmb_pkg::OP_RACK);
		item_in.op      = i2cmb_pkg::op_t'(s_tuser[3:1]);
		item_in.tx_byte = s_tdata[7:0];
		item_in.sda_in  = s_tdata[8];
	end

	assign push      = valid_s1 & ~q_stat.full;
	assign s_tready  = ~valid_s1 | ~q_stat.full;
	assign push_item = item_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== hdl/i2cmb_queue.sv =====
// Short word queue between the front and the back part.
`timescale 1ns / 1ps

module i2cmb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cmb_pkg::item_t   push_item,
	input  logic               pop,
	output i2cmb_pkg::item_t   pop_item,
	output i2cmb_pkg::q_stat_t q_stat
);

	i2cmb_pkg::item_t                   mem_q [i2cmb_pkg::QDEPTH];
	logic [i2cmb_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [i2cmb_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [i2cmb_pkg::QCNT_W-1:0]       count_q;

	assign q_stat.full  = (count_q == i2cmb_pkg::QCNT_W'(i2cmb_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/i2cmb_engine.sv =====
// Back part: steps the bit sequencer one tick per word and registers the result.
`timescale 1ns / 1ps

module i2cmb_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [i2cmb_pkg::HOLD_W-1:0]       step_ticks,
	input  logic                               q_empty,
	input  i2cmb_pkg::item_t                   item,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [i2cmb_pkg::TDATA_W-1:0]      m_tdata  // scl[0], sda[1], busy[2], done[3],
	                                                    // rx_byte[11:4], rx_ack[12], zero pad
);

	// Sequencer state
	logic                              scl_q, sda_q, busy_q, ack_q;
	i2cmb_pkg::op_t                    op_q;
	logic [i2cmb_pkg::IDX_W-1:0]       idx_q;
	logic [1:0]                        phase_q;
	logic [i2cmb_pkg::HOLD_W-1:0]      hold_q;
	logic [i2cmb_pkg::BYTE_W-1:0]      tx_q, rx_q;

	logic                              scl_n, sda_n, busy_n, ack_n, done_n, do_act;
	i2cmb_pkg::op_t                    op_n;
	logic [i2cmb_pkg::IDX_W-1:0]       idx_n;
	logic [1:0]                        phase_n;
	logic [i2cmb_pkg::HOLD_W-1:0]      hold_n, step_eff;
	logic [i2cmb_pkg::BYTE_W-1:0]      tx_n, rx_n;

	logic                              m_tvalid_q;
	i2cmb_pkg::result_t                res_q, res_n;

	assign pop      = ~q_empty & (~m_tvalid_q | m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(i2cmb_pkg::TDATA_W - $bits(i2cmb_pkg::result_t)){1'b0}}, res_q};
	assign step_eff = (step_ticks == '0) ? i2cmb_pkg::HOLD_W'(1) : step_ticks;

	// One tick of the sequencer
	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		busy_n  = busy_q;
		ack_n   = ack_q;
		op_n    = op_q;
		idx_n   = idx_q;
		phase_n = phase_q;
		hold_n  = hold_q;
		tx_n    = tx_q;
		rx_n    = rx_q;
		done_n  = 1'b0;
		do_act  = 1'b0;

		if (busy_q) begin
			if (hold_q > i2cmb_pkg::HOLD_W'(1)) begin
				hold_n = hold_q - 1'b1;
			end else begin
				idx_n = idx_q + 1'b1;
				// read: slot phases count from the first SCL high
				if ((op_q == i2cmb_pkg::OP_READ && idx_q == '0) || phase_q == 2'd2)
					phase_n = 2'd0;
				else
					phase_n = phase_q + 2'd1;
				do_act = 1'b1;
			end
		end else if (item.cmd_ok) begin
			op_n    = item.op;
			idx_n   = '0;
			phase_n = 2'd0;
			tx_n    = item.tx_byte;
			if (item.op == i2cmb_pkg::OP_READ)
				rx_n = '0;
			busy_n  = 1'b1;
			do_act  = 1'b1;
		end

		// Pin action
		if (do_act) begin
			unique case (i2cmb_pkg::action_kind(op_n, idx_n, phase_n))
				i2cmb_pkg::ACT_SDA_LO: sda_n = 1'b0;
				i2cmb_pkg::ACT_SDA_HI: sda_n = 1'b1;
				i2cmb_pkg::ACT_SCL_LO: scl_n = 1'b0;
				i2cmb_pkg::ACT_SCL_HI: scl_n = 1'b1;
				i2cmb_pkg::ACT_SDA_DATA: begin
					sda_n = tx_n[i2cmb_pkg::BYTE_W-1];
					tx_n  = {tx_n[i2cmb_pkg::BYTE_W-2:0], 1'b0};
				end
				i2cmb_pkg::ACT_SDA_ACK: sda_n = (tx_n != '0);
				i2cmb_pkg::ACT_RD_BIT:  rx_n  = {rx_n[i2cmb_pkg::BYTE_W-2:0], item.sda_in};
				default:                ack_n = item.sda_in;
			endcase
			hold_n = step_eff;
		end

		// End of the last action
		if (busy_q && hold_n <= i2cmb_pkg::HOLD_W'(1) &&
		    ({1'b0, idx_n} + 6'd1) >= {1'b0, i2cmb_pkg::seq_len(op_q)}) begin
			busy_n = 1'b0;
			hold_n = '0;
			done_n = 1'b1;
		end

		res_n.scl     = scl_n;
		res_n.sda     = sda_n;
		res_n.busy    = busy_n;
		res_n.done    = done_n;
		res_n.rx_byte = rx_n;
		res_n.rx_ack  = ack_n;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			busy_q  <= 1'b0;
			ack_q   <= 1'b1;
			op_q    <= i2cmb_pkg::OP_START;
			idx_q   <= '0;
			phase_q <= 2'd0;
			hold_q  <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
		end else if (pop) begin
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			busy_q  <= busy_n;
			ack_q   <= ack_n;
			op_q    <= op_n;
			idx_q   <= idx_n;
			phase_q <= phase_n;
			hold_q  <= hold_n;
			tx_q    <= tx_n;
			rx_q    <= rx_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	// A running command always holds its current action for at least one tick
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> hold_q != '0)
		else $error("busy with zero hold count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < i2cmb_pkg::seq_len(op_q))
		else $error("action index past end of sequence");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> phase_q != 2'd3)
		else $error("bit slot phase out of range");

	// A waiting result word agrees with the sequencer state it was taken from
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (res_q.busy == busy_q && res_q.scl == scl_q && res_q.sda == sda_q))
		else $error("result word out of step with sequencer");

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// A word accepted on s_* is registered in the front stage, written to the queue, then registered as a result on m_*.
// Throughput: one word per cycle while m_tready does not stall the output; the sequencer steps once per word.
// Each word gives exactly one result word; the four-entry queue absorbs output stalls.
// Reset (arst_n low, asynchronous): lines released, engine idle, queue empty, step_ticks 10.
// Top level of the I2C master bit engine: front stage, queue, sequencer and step register.
`timescale 1ns / 1ps

module i2c_master_bit_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [i2cmb_pkg::TDATA_W-1:0]     s_tdata,  // tx_byte[7:0], sda_in[8], zero pad
	input  logic [i2cmb_pkg::TUSER_W-1:0]     s_tuser,  // cmd_valid[0], opcode[3:1]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [i2cmb_pkg::TDATA_W-1:0]     m_tdata,  // scl[0], sda[1], busy[2], done[3],
	                                                    // rx_byte[11:4], rx_ack[12], zero pad
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2cmb_pkg::HOLD_W-1:0]      cfg_data  // step_ticks
);

	logic                          push, pop;
	i2cmb_pkg::item_t              push_item, pop_item;
	i2cmb_pkg::q_stat_t            q_stat;
	logic [i2cmb_pkg::HOLD_W-1:0]  step_ticks_q;

	assign cfg_ready = 1'b1;

	// Step length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= i2cmb_pkg::STEP_RESET;
		end else if (cfg_valid) begin
			step_ticks_q <= cfg_data;
		end
	end

	i2cmb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	i2cmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	i2cmb_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_ticks (step_ticks_q),
		.q_empty    (q_stat.empty),
		.item       (pop_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== verif/i2c_bit_checker.sv =====
// Checker for the I2C master bit engine: predicts every result word and compares it.
`timescale 1ns / 1ps

module i2c_bit_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [i2cmb_pkg::TDATA_W-1:0]     s_tdata,  // tx_byte[7:0], sda_in[8], zero pad
	input  logic [i2cmb_pkg::TUSER_W-1:0]     s_tuser,  // cmd_valid[0], opcode[3:1]
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [i2cmb_pkg::TDATA_W-1:0]     m_tdata,  // scl[0], sda[1], busy[2], done[3],
	                                                    // rx_byte[11:4], rx_ack[12], zero pad
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [i2cmb_pkg::HOLD_W-1:0]      cfg_data,
	output int                                errors,
	output int                                pending
);

	// What a single pin action does
	typedef enum logic [2:0] {
		PIN_SDA_LOW,
		PIN_SDA_HIGH,
		PIN_SCL_LOW,
		PIN_SCL_HIGH,
		PIN_SDA_BIT,
		PIN_SDA_ACK,
		PIN_READ_BIT,
		PIN_READ_ACK
	} pin_t;

	// One predicted result word
	typedef struct packed {
		logic                         scl;
		logic                         sda;
		logic                         busy;
		logic                         done;
		logic [i2cmb_pkg::BYTE_W-1:0] rx_byte;
		logic                         rx_ack;
	} pins_t;

	// Predictor state
	logic [i2cmb_pkg::HOLD_W-1:0] hold_ticks;
	logic                         line_scl;
	logic                         line_sda;
	logic                         seq_busy;
	i2cmb_pkg::op_t               cur_op;
	logic [i2cmb_pkg::IDX_W-1:0]  act_no;
	logic [i2cmb_pkg::HOLD_W-1:0] ticks_left;
	logic [i2cmb_pkg::BYTE_W-1:0] wr_bits;
	logic [i2cmb_pkg::BYTE_W-1:0] rd_bits;
	logic                         ack_bit;

	pins_t pins_due[$];
	pins_t want;

	function automatic int actions_in(i2cmb_pkg::op_t o);
		case (o)
			i2cmb_pkg::OP_START:                   return 4;
			i2cmb_pkg::OP_STOP, i2cmb_pkg::OP_SACK: return 3;
			i2cmb_pkg::OP_WRITE:                   return 24;
			i2cmb_pkg::OP_READ:                    return 25;
			default:                               return 4;
		endcase
	endfunction

	// Pin action at position i of a command
	function automatic pin_t pin_at(i2cmb_pkg::op_t o, int i);
		pin_t p;
		case (o)
			i2cmb_pkg::OP_START: begin
				case (i)
					0:       p = PIN_SDA_HIGH;
					1:       p = PIN_SCL_HIGH;
					2:       p = PIN_SDA_LOW;
					default: p = PIN_SCL_LOW;
				endcase
			end
			i2cmb_pkg::OP_STOP: begin
				case (i)
					0:       p = PIN_SDA_LOW;
					1:       p = PIN_SCL_HIGH;
					default: p = PIN_SDA_HIGH;
				endcase
			end
			i2cmb_pkg::OP_WRITE: begin
				case (i % 3)
					0:       p = PIN_SDA_BIT;
					1:       p = PIN_SCL_HIGH;
					default: p = PIN_SCL_LOW;
				endcase
			end
			i2cmb_pkg::OP_READ: begin
				if (i == 0) begin
					p = PIN_SDA_HIGH;
				end else begin
					case ((i - 1) % 3)
						0:       p = PIN_SCL_HIGH;
						1:       p = PIN_READ_BIT;
						default: p = PIN_SCL_LOW;
					endcase
				end
			end
			i2cmb_pkg::OP_SACK: begin
				case (i)
					0:       p = PIN_SDA_ACK;
					1:       p = PIN_SCL_HIGH;
					default: p = PIN_SCL_LOW;
				endcase
			end
			default: begin
				case (i)
					0:       p = PIN_SDA_HIGH;
					1:       p = PIN_SCL_HIGH;
					2:       p = PIN_READ_ACK;
					default: p = PIN_SCL_LOW;
				endcase
			end
		endcase
		return p;
	endfunction

	// Carry out the current action and restart its hold time
	task automatic do_pin(logic sda_now);
		case (pin_at(cur_op, int'(act_no)))
			PIN_SDA_LOW:  line_sda = 1'b0;
			PIN_SDA_HIGH: line_sda = 1'b1;
			PIN_SCL_LOW:  line_scl = 1'b0;
			PIN_SCL_HIGH: line_scl = 1'b1;
			PIN_SDA_BIT: begin
				line_sda = wr_bits[7];
				wr_bits  = wr_bits << 1;
			end
			PIN_SDA_ACK:  line_sda = |wr_bits;
			PIN_READ_BIT: rd_bits = {rd_bits[6:0], sda_now};
			default:      ack_bit = sda_now;
		endcase
		// zero hold is taken as one tick
		ticks_left = (hold_ticks == '0) ? 16'd1 : hold_ticks;
	endtask

	// One tick of the engine; queues the word it should answer with
	task automatic tick_engine(logic cv, logic [2:0] opc, logic [i2cmb_pkg::BYTE_W-1:0] txb,
		logic sda_now);
		logic fin;
		fin = 1'b0;
		if (seq_busy) begin
			if (ticks_left > 16'd1) begin
				ticks_left = ticks_left - 16'd1;
			end else begin
				act_no = act_no + 5'd1;
				do_pin(sda_now);
			end
			if (ticks_left <= 16'd1 && int'(act_no) + 1 >= actions_in(cur_op)) begin
				seq_busy   = 1'b0;
				ticks_left = '0;
				fin        = 1'b1;
			end
		end else if (cv && opc <= i2cmb_pkg::OP_RACK) begin
			cur_op  = i2cmb_pkg::op_t'(opc);
			act_no  = '0;
			wr_bits = txb;
			if (cur_op == i2cmb_pkg::OP_READ)
				rd_bits = '0;
			seq_busy = 1'b1;
			do_pin(sda_now);
		end
		pins_due.push_back('{line_scl, line_sda, seq_busy, fin, rd_bits, ack_bit});
	endtask

	task automatic check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			errors++;
		end
	endtask

	// Watch the three channels; prediction goes ahead of the compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks = i2cmb_pkg::STEP_RESET;
			line_scl   = 1'b1;
			line_sda   = 1'b1;
			seq_busy   = 1'b0;
			cur_op     = i2cmb_pkg::OP_START;
			act_no     = '0;
			ticks_left = '0;
			wr_bits    = '0;
			rd_bits    = '0;
			ack_bit    = 1'b1;
			errors     = 0;
			pins_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				hold_ticks = cfg_data;
			if (s_tvalid && s_tready)
				tick_engine(s_tuser[0], s_tuser[3:1], s_tdata[7:0], s_tdata[8]);
			if (m_tvalid && m_tready) begin
				if (pins_due.size() == 0) begin
					$error("result word with no prediction waiting");
					errors++;
				end else begin
					want = pins_due.pop_front();
					check_field("scl_level", want.scl, m_tdata[0]);
					check_field("sda_level", want.sda, m_tdata[1]);
					check_field("busy_res", want.busy, m_tdata[2]);
					check_field("done_res", want.done, m_tdata[3]);
					check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
					check_field("rx_ack", want.rx_ack, m_tdata[12]);
				end
			end
		end
		pending = pins_due.size();
	end

endmodule

// ===== verif/tb.sv =====
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_TICKS = 1000;
	localparam int SDA_RANDOM   = -1;

	// opcodes outside the command set, ignored by the engine
	localparam logic [2:0] OP_BAD_LO = 3'd6;
	localparam logic [2:0] OP_BAD_HI = 3'd7;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [i2cmb_pkg::TDATA_W-1:0] s_tdata   = '0;
	logic [i2cmb_pkg::TUSER_W-1:0] s_tuser   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b1;
	logic [i2cmb_pkg::TDATA_W-1:0] m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [i2cmb_pkg::HOLD_W-1:0]  cfg_data  = '0;

	int                           errors;
	int                           pending;
	int                           ticks_sent  = 0;
	int                           burst_left  = 0;
	int                           idle_cycles = 0;
	int                           rx_hold     = 0;
	int                           rx_cyc      = 0;
	bit                           gaps_on     = 1'b1;
	rx_mode_t                     rx_mode     = RX_ALWAYS;
	logic [i2cmb_pkg::HOLD_W-1:0] step_now    = i2cmb_pkg::STEP_RESET;

	logic [i2cmb_pkg::HOLD_W-1:0] phase_steps [5] = '{16'd2, 16'd0, 16'd1, 16'd3, 16'd4};

	i2c_master_bit_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	i2c_bit_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		rx_cyc++;
		case (rx_mode)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: m_tready <= ((rx_cyc % 5) < 3);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_hold = $urandom_range(1, 12);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// Watchdog: cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic line_level(int lvl);
		return (lvl < 0) ? 1'($urandom_range(0, 1)) : lvl[0];
	endfunction

	// Ticks a command keeps the engine busy at the current step
	function automatic int cmd_ticks(logic [2:0] op);
		int n;
		case (op)
			i2cmb_pkg::OP_START, i2cmb_pkg::OP_RACK: n = 4;
			i2cmb_pkg::OP_STOP, i2cmb_pkg::OP_SACK:  n = 3;
			i2cmb_pkg::OP_WRITE:                     n = 24;
			i2cmb_pkg::OP_READ:                      n = 25;
			default:                                 return 1;
		endcase
		return n * ((step_now == '0) ? 1 : int'(step_now));
	endfunction

	// One tick word, sent in bursts with random gaps while gaps_on is set
	task automatic send_tick(logic cv, logic [2:0] op, logic [7:0] txb, logic sda);
		if (gaps_on && burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, sda, txb};
		s_tuser  <= {op, cv};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		ticks_sent++;
	endtask

	// Random tick; any command it carries lands while busy and is dropped
	task automatic noise_tick(int lvl);
		send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
			line_level(lvl));
	endtask

	// Tick that cannot start a command
	task automatic idle_tick();
		logic cv;
		cv = 1'($urandom_range(0, 1));
		send_tick(cv, cv ? ($urandom_range(0, 1) ? OP_BAD_LO : OP_BAD_HI)
			: 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Issue a command and keep ticking until it should be done
	task automatic run_cmd(logic [2:0] op, logic [7:0] txb, int lvl);
		int n;
		n = cmd_ticks(op);
		send_tick(1'b1, op, txb, line_level(lvl));
		repeat (n - 1) noise_tick(lvl);
	endtask

	// Hold the sender until every result word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_step(logic [i2cmb_pkg::HOLD_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		step_now = val;
	endtask

	// Mostly well-formed transfers, some lone commands
	task automatic random_transfer();
		int n_bytes;
		bit reading;
		if ($urandom_range(0, 4) != 0) begin
			run_cmd(i2cmb_pkg::OP_START, 8'($urandom), SDA_RANDOM);
			run_cmd(i2cmb_pkg::OP_WRITE, 8'($urandom), SDA_RANDOM);
			run_cmd(i2cmb_pkg::OP_RACK, 8'($urandom), SDA_RANDOM);
			n_bytes = $urandom_range(1, 3);
			reading = 1'($urandom_range(0, 1));
			repeat (n_bytes) begin
				if (reading) begin
					run_cmd(i2cmb_pkg::OP_READ, 8'($urandom), SDA_RANDOM);
					run_cmd(i2cmb_pkg::OP_SACK, $urandom_range(0, 1) ? 8'h00 : 8'($urandom),
						SDA_RANDOM);
				end else begin
					run_cmd(i2cmb_pkg::OP_WRITE, 8'($urandom), SDA_RANDOM);
					run_cmd(i2cmb_pkg::OP_RACK, 8'($urandom), SDA_RANDOM);
				end
			end
			// no stop now and then, so the next start is a repeated one
			if ($urandom_range(0, 3) != 0)
				run_cmd(i2cmb_pkg::OP_STOP, 8'($urandom), SDA_RANDOM);
		end else begin
			run_cmd(3'($urandom_range(0, 7)), 8'($urandom), int'($urandom_range(0, 2)) - 1);
		end
		repeat ($urandom_range(0, 3)) idle_tick();
	endtask

	initial begin
		int target;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// step_ticks at its reset value
		run_cmd(i2cmb_pkg::OP_START, 8'h00, SDA_RANDOM);

		// directed commands at one tick per action
		set_step(16'd1);
		send_tick(1'b0, i2cmb_pkg::OP_START, 8'hFF, 1'b1);
		run_cmd(OP_BAD_LO, 8'h00, SDA_RANDOM);
		run_cmd(OP_BAD_HI, 8'hFF, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_START, 8'h00, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_WRITE, 8'hFF, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_RACK, 8'h00, 0);
		run_cmd(i2cmb_pkg::OP_WRITE, 8'h00, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_RACK, 8'hFF, 1);
		run_cmd(i2cmb_pkg::OP_WRITE, 8'hA5, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_READ, 8'h00, 1);
		run_cmd(i2cmb_pkg::OP_SACK, 8'h00, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_READ, 8'hFF, 0);
		run_cmd(i2cmb_pkg::OP_SACK, 8'h01, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_READ, 8'h5A, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_SACK, 8'hFF, SDA_RANDOM);
		run_cmd(i2cmb_pkg::OP_STOP, 8'h00, SDA_RANDOM);

		// long hold on the first action, then a rewrite while it is still held
		set_step(16'd100);
		gaps_on = 1'b0;
		rx_mode = RX_RANDOM;
		send_tick(1'b1, i2cmb_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
		repeat (49) noise_tick(SDA_RANDOM);
		set_step(16'd2);
		repeat (100 - 50 + 2 * 2) noise_tick(SDA_RANDOM);

		// random phases over several step settings
		foreach (phase_steps[p]) begin
			set_step((p == 4) ? 16'($urandom_range(1, 5)) : phase_steps[p]);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			gaps_on = (p != 2);
			target  = ticks_sent + RANDOM_TICKS / 5;
			while (ticks_sent < target)
				random_transfer();
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/i2cmb_pkg.sv
hdl/i2cmb_front.sv
hdl/i2cmb_queue.sv
hdl/i2cmb_engine.sv
hdl/i2c_master_bit_engine.sv
verif/i2c_bit_checker.sv
verif/tb.sv
